[hdl/pps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority scheduler package
// Shared types and constants for the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam logic [15:0] QUANTUM_RESET = 16'd500;

	localparam logic KIND_ARRIVAL = 1'b0;
	localparam logic KIND_TICK    = 1'b1;

	// Command handed from the front end to the execution engine.
	typedef struct packed {
		logic        kind;
		logic [15:0] task_id;
		logic [23:0] burst_len;
		logic [7:0]  prio_level;
	} pps_cmd_t;

	typedef struct packed {
		logic        ran_valid;
		logic [15:0] ran_id;
		logic        finished;
		logic        preempted;
		logic        dropped;
	} pps_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RUN,
		ST_WRITE,
		ST_OUT
	} pps_state_t;

endpackage

[hdl/pps_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler front end
// Accepts input transactions into a two-entry command queue.
// ----------------------------------------------------------------------------
module pps_front import pps_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  pps_cmd_t in_cmd,
	output logic     cmd_valid,
	input  logic     cmd_take,
	output pps_cmd_t cmd
);
	pps_cmd_t   q_mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push, pop;

	assign in_stall  = (count_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (count_q != 2'd0);
	assign pop       = cmd_valid && cmd_take;
	assign cmd       = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wr_ptr_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 2'd2 |-> !push) else $error("queue overflow");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("bad queue count");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != 2'd0) else $error("pop from empty queue");
endmodule

[hdl/pps_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler execution engine
// Holds the ready table and current task; scans one slot per cycle.
// ----------------------------------------------------------------------------
module pps_engine import pps_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] quantum_len,
	input  logic        cmd_valid,
	output logic        cmd_take,
	input  pps_cmd_t    cmd,
	output logic        out_valid,
	input  logic        out_stall,
	output pps_res_t    res
);
	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	logic [TABLE_DEPTH-1:0] slot_valid_q;
	logic [15:0] slot_id_q    [TABLE_DEPTH];
	logic [23:0] slot_rem_q   [TABLE_DEPTH];
	logic [7:0]  slot_prio_q  [TABLE_DEPTH];
	logic [15:0] slot_order_q [TABLE_DEPTH];

	logic [15:0] order_q;
	logic        cur_valid_q;
	logic [15:0] cur_id_q;
	logic [23:0] cur_rem_q;
	logic [7:0]  cur_prio_q;

	pps_state_t  state_q, state_d;
	pps_cmd_t    cmd_q;
	logic [IW:0] idx_q;
	logic        best_found_q;
	logic [IW-1:0] best_q;
	logic [7:0]  best_prio_q;
	logic [15:0] best_age_q;
	logic        free_found_q;
	logic [IW-1:0] free_q;
	pps_res_t    res_q;

	logic [IW-1:0] idx;
	logic [15:0]   age;
	logic          better;

	assign idx    = idx_q[IW-1:0];
	assign age    = order_q - slot_order_q[idx];
	assign better = slot_valid_q[idx] && (!best_found_q || slot_prio_q[idx] < best_prio_q ||
		(slot_prio_q[idx] == best_prio_q && age > best_age_q));
	assign out_valid = (state_q == ST_OUT);
	assign res       = res_q;

	always_comb begin
		state_d  = state_q;
		cmd_take = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd_take = cmd_valid;
				if (cmd_valid) state_d = ST_SCAN;
			end
			ST_SCAN: if (idx_q == (IW+1)'(TABLE_DEPTH - 1)) state_d = ST_RUN;
			ST_RUN:   state_d = ST_WRITE;
			ST_WRITE: state_d = ST_OUT;
			ST_OUT:   if (!out_stall) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Slot payload needs no reset; reads are qualified by the valid bits.
	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE && cmd_q.kind == KIND_ARRIVAL && free_found_q) begin
			slot_id_q[free_q]    <= cmd_q.task_id;
			slot_rem_q[free_q]   <= cmd_q.burst_len;
			slot_prio_q[free_q]  <= cmd_q.prio_level;
			slot_order_q[free_q] <= order_q;
		end
		// The displaced task takes the slot of the task that replaces it.
		if (state_q == ST_RUN && cmd_q.kind == KIND_TICK && cur_valid_q &&
				best_found_q && best_prio_q < cur_prio_q) begin
			slot_id_q[best_q]    <= cur_id_q;
			slot_rem_q[best_q]   <= cur_rem_q;
			slot_prio_q[best_q]  <= cur_prio_q;
			slot_order_q[best_q] <= order_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			order_q      <= '0;
			cur_valid_q  <= 1'b0;
			cur_id_q     <= '0;
			cur_rem_q    <= '0;
			cur_prio_q   <= '0;
			idx_q        <= '0;
			best_found_q <= 1'b0;
			best_q       <= '0;
			best_prio_q  <= '0;
			best_age_q   <= '0;
			free_found_q <= 1'b0;
			free_q       <= '0;
			cmd_q        <= '0;
			res_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cmd_q        <= cmd;
					idx_q        <= '0;
					best_found_q <= 1'b0;
					free_found_q <= 1'b0;
					res_q        <= '0;
				end
				ST_SCAN: begin
					if (better) begin
						best_found_q <= 1'b1;
						best_q       <= idx;
						best_prio_q  <= slot_prio_q[idx];
						best_age_q   <= age;
					end
					if (!slot_valid_q[idx] && !free_found_q) begin
						free_found_q <= 1'b1;
						free_q       <= idx;
					end
					idx_q <= idx_q + (IW+1)'(1);
				end
				ST_RUN: begin
					// Pick the task that runs this tick.
					if (cmd_q.kind == KIND_TICK) begin
						if (!cur_valid_q) begin
							if (best_found_q) begin
								cur_valid_q <= 1'b1;
								cur_id_q    <= slot_id_q[best_q];
								cur_rem_q   <= slot_rem_q[best_q];
								cur_prio_q  <= best_prio_q;
								slot_valid_q[best_q] <= 1'b0;
							end
						end else if (best_found_q && best_prio_q < cur_prio_q) begin
							cur_id_q   <= slot_id_q[best_q];
							cur_rem_q  <= slot_rem_q[best_q];
							cur_prio_q <= best_prio_q;
							order_q    <= order_q + 16'd1;
							res_q.preempted <= 1'b1;
						end
					end
				end
				ST_WRITE: begin
					if (cmd_q.kind == KIND_ARRIVAL) begin
						if (free_found_q) begin
							slot_valid_q[free_q] <= 1'b1;
							order_q <= order_q + 16'd1;
						end else begin
							res_q.dropped <= 1'b1;
						end
					end else if (cur_valid_q) begin
						res_q.ran_valid <= 1'b1;
						res_q.ran_id    <= cur_id_q;
						if (cur_rem_q <= {8'd0, quantum_len}) begin
							cur_rem_q   <= '0;
							cur_valid_q <= 1'b0;
							res_q.finished <= 1'b1;
						end else begin
							cur_rem_q <= cur_rem_q - {8'd0, quantum_len};
						end
					end
				end
				ST_OUT: ;
				default: ;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result lost");
	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(res_q.dropped && res_q.ran_valid)) else $error("bad flags");
	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && res_q.finished |-> !cur_valid_q) else $error("finished task still current");
endmodule

[hdl/preemptive_priority_scheduler_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Preemptive priority scheduler core
// Ready table of TABLE_DEPTH tasks with priority and FIFO-tie preemption.
// ----------------------------------------------------------------------------
// Each transaction yields exactly one result. The engine handles one
// transaction at a time: a take state, a scan of one table slot per cycle
// for the minimum and a free slot, then run, write and result states, the
// result held through any output stall. A two-entry queue in front keeps
// accepting transactions while the engine works, until the queue is full.
module preemptive_priority_scheduler_core import pps_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [15:0] task_id,
	input  logic [23:0] burst_len,
	input  logic [7:0]  prio_level,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        ran_valid,
	output logic [15:0] ran_id,
	output logic        finished,
	output logic        preempted,
	output logic        dropped
);
	logic [15:0] quantum_q;
	pps_cmd_t    in_cmd, cmd;
	logic        cmd_valid, cmd_take;
	pps_res_t    res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) quantum_q <= QUANTUM_RESET;
		else if (cfg_we) quantum_q <= cfg_wdata;
	end

	assign in_cmd = '{kind: kind, task_id: task_id, burst_len: burst_len,
		prio_level: prio_level};

	pps_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_cmd(in_cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
	);

	pps_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
		.clk(clk), .arst_n(arst_n), .quantum_len(quantum_q),
		.cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
		.out_valid(out_valid), .out_stall(out_stall), .res(res)
	);

	assign ran_valid = res.ran_valid;
	assign ran_id    = res.ran_id;
	assign finished  = res.finished;
	assign preempted = res.preempted;
	assign dropped   = res.dropped;
endmodule
